FILE: sv/stbs_pkg.sv
// Shared types and constants for the sorted table binary search block.
package stbs_pkg;

   // Fixed field widths of the item and result beats
   localparam int KIND_BITS  = 1;
   localparam int INDEX_BITS = 8;
   localparam int ITEM_BITS  = 32;
   localparam int COUNT_BITS = 9;
   localparam int POS_BITS   = 8;

   // Defaults for the top-level parameters
   localparam int DEF_TABLE_DEPTH = 256;
   localparam int DEF_VALUE_BITS  = 32;

   // Item kinds
   localparam logic [KIND_BITS-1:0] KIND_WRITE  = 1'b0;
   localparam logic [KIND_BITS-1:0] KIND_SEARCH = 1'b1;

   typedef struct packed {
      logic [KIND_BITS-1:0]         kind;
      logic [INDEX_BITS-1:0]        entry_index;
      logic signed [ITEM_BITS-1:0]  item_value;
   } req_type;

   typedef struct packed {
      logic                found;
      logic [POS_BITS-1:0] position;
   } rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic write;   // store the accepted write beat
      logic load;    // take the key and set up the bounds
      logic probe;   // issue the midpoint read
      logic step;    // compare and narrow the bounds
      logic post;    // load the result register
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic range_empty;  // low bound has passed the high bound
      logic match;        // key equals the entry just read
   } sts_type;

endpackage

FILE: sv/stbs_ram.sv
// Generic simple dual-port RAM with registered read data.
module stbs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/stbs_dpath.sv
// Datapath: table memory, search bounds, key compare and result register.
module stbs_dpath #(
   parameter int TABLE_DEPTH = 256,
   parameter int VALUE_BITS  = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  stbs_pkg::req_type                  req_data,
   input  logic                               csr_wr_en,
   input  logic [stbs_pkg::COUNT_BITS-1:0]    csr_wr_data,
   input  stbs_pkg::cmd_type                  cmd,
   output stbs_pkg::sts_type                  sts,
   output stbs_pkg::rsp_type                  rsp_data
);
   import stbs_pkg::*;

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   logic [COUNT_BITS-1:0]        count_ff;
   logic [CW-1:0]                lo_ff, lo_in;
   logic [CW-1:0]                hend_ff, hend_in;   // one past the high bound
   logic [AW-1:0]                mid_ff, mid_in;
   logic signed [VALUE_BITS-1:0] key_ff, key_in;
   logic                         hit_ff, hit_in;
   rsp_type                      rsp_ff, rsp_in;

   logic [VALUE_BITS+ITEM_BITS-1:0] value_wide;
   logic [VALUE_BITS-1:0]           value_cut;
   logic [AW+INDEX_BITS-1:0]        idx_wide;
   logic [AW-1:0]                   wr_addr;
   logic                            wr_en;
   logic [CW:0]                     mid_sum;
   logic [CW-1:0]                   span;
   logic [VALUE_BITS-1:0]           rd_data;
   logic signed [VALUE_BITS-1:0]    entry;
   logic [AW+POS_BITS-1:0]          mid_wide;

   // Item value taken in its low VALUE_BITS bits
   assign value_wide = (VALUE_BITS + ITEM_BITS)'($unsigned(req_data.item_value));
   assign value_cut  = value_wide[VALUE_BITS-1:0];

   // Table writes; indexes past the table are dropped
   assign idx_wide = (AW + INDEX_BITS)'(req_data.entry_index);
   assign wr_addr  = idx_wide[AW-1:0];
   assign wr_en    = cmd.write && (32'(req_data.entry_index) < TABLE_DEPTH);

   stbs_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (value_cut),
      .rd_addr (mid_in),
      .rd_data (rd_data)
   );

   // Entry count register, saturated to the table depth when a search starts
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_wr_en) begin
         count_ff <= csr_wr_data;
      end
   end

   assign span = (32'(count_ff) > TABLE_DEPTH) ? CW'(TABLE_DEPTH) : CW'(count_ff);

   // Midpoint: floor((lo + hi) / 2) with hi = hend - 1
   assign mid_sum = (CW + 1)'(lo_ff) + (CW + 1)'(hend_ff) - (CW + 1)'(1);
   assign entry   = $signed(rd_data);

   assign sts.range_empty = !(lo_ff < hend_ff);
   assign sts.match       = (entry == key_ff);

   // Bounds, key and hit flag
   always_comb begin
      lo_in   = lo_ff;
      hend_in = hend_ff;
      mid_in  = mid_ff;
      key_in  = key_ff;
      hit_in  = hit_ff;
      if (cmd.load) begin
         lo_in   = '0;
         hend_in = span;
         key_in  = $signed(value_cut);
         hit_in  = 1'b0;
      end
      if (cmd.probe) begin
         mid_in = mid_sum[AW:1];
      end
      if (cmd.step) begin
         if (sts.match) begin
            hit_in = 1'b1;
         end else if (key_ff > entry) begin
            lo_in = CW'(mid_ff) + CW'(1);
         end else begin
            hend_in = CW'(mid_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lo_ff   <= '0;
         hend_ff <= '0;
         hit_ff  <= 1'b0;
      end else begin
         lo_ff   <= lo_in;
         hend_ff <= hend_in;
         hit_ff  <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      mid_ff <= mid_in;
      key_ff <= key_in;
   end

   // Result register; position reads 0 on a miss
   assign mid_wide = (AW + POS_BITS)'(mid_ff);

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.post) begin
         rsp_in.found    = hit_ff;
         rsp_in.position = hit_ff ? mid_wide[POS_BITS-1:0] : '0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

FILE: sv/stbs_ctrl.sv
// Controller: sequences write beats and the probe loop of each search.
module stbs_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [stbs_pkg::KIND_BITS-1:0]    req_kind,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  stbs_pkg::sts_type                 sts,
   output stbs_pkg::cmd_type                 cmd
);
   import stbs_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_PROBE  = 2'd1;
   localparam logic [1:0] ST_CHECK  = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       req_take;
   logic       slot_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_kind == KIND_SEARCH) begin
                  cmd.load = 1'b1;
                  state_in = ST_PROBE;
               end else begin
                  cmd.write = 1'b1;
               end
            end
         end
         ST_PROBE: begin
            if (sts.range_empty) begin
               state_in = ST_FINISH;
            end else begin
               cmd.probe = 1'b1;
               state_in  = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.step = 1'b1;
            state_in = sts.match ? ST_FINISH : ST_PROBE;
         end
         ST_FINISH: begin
            if (slot_free) begin
               cmd.post = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result valid: set on post, cleared when the beat is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.post) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // A waiting result is never overwritten
   a_post_free: assert property (@(posedge clock) disable iff (reset)
      cmd.post |-> slot_free)
      else $error("result posted over a waiting beat");

   // Posting a result raises valid next cycle
   a_post_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.post |=> rsp_valid_ff)
      else $error("posted result not valid");

   // Every compare follows a read issued the cycle before
   a_check_after_probe: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK) |-> $past(cmd.probe))
      else $error("compare without a preceding read");

   // An accepted search starts the probe loop
   a_search_starts: assert property (@(posedge clock) disable iff (reset)
      (req_take && (req_kind == KIND_SEARCH)) |=> (state_ff == ST_PROBE))
      else $error("search beat did not start probing");

endmodule

FILE: sv/sorted_table_binary_search.sv
// Sorted table binary search: top level joining controller and datapath.
//
// Holds a table of TABLE_DEPTH signed entries of VALUE_BITS bits, kept in ascending
// order by software. A write beat (kind 0) stores one entry and gives no result;
// indexes at or past the depth are dropped. A search beat (kind 1) runs a binary search
// over the first csr entries (saturated to the depth) and returns one beat with found
// and position (0 on a miss). Each probe is a registered memory read followed by the
// compare. A search that finishes while the previous result beat is still stalled at
// the output waits until that beat is taken. Searches must only read entries that were
// written since reset; the block itself does not enforce this. The next beat is
// accepted while a finished result still waits on the output register. Write the csr
// only while idle.
module sorted_table_binary_search #(
   parameter int TABLE_DEPTH = stbs_pkg::DEF_TABLE_DEPTH,
   parameter int VALUE_BITS  = stbs_pkg::DEF_VALUE_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  stbs_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output stbs_pkg::rsp_type               rsp_data,
   input  logic                            csr_wr_en,
   input  logic [stbs_pkg::COUNT_BITS-1:0] csr_wr_data
);
   import stbs_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Sequencer
   stbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_kind  (req_data.kind),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Table, bounds and compare
   stbs_dpath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .VALUE_BITS  (VALUE_BITS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_data    (rsp_data)
   );

endmodule

FILE: tb/stbs_result_check.sv
`timescale 1ns / 1ps
// Result checker for the sorted table binary search: tracks the table, predicts, compares.
module stbs_result_check (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  stbs_pkg::req_type               req_data,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  stbs_pkg::rsp_type               rsp_data,
   input  logic                            csr_wr_en,
   input  logic [stbs_pkg::COUNT_BITS-1:0] csr_wr_data,
   output int                              error_count,
   output int                              outstanding,
   output int                              results_checked,
   output int                              hits_seen
);
   import stbs_pkg::*;

   localparam int DEPTH      = DEF_TABLE_DEPTH;
   localparam int REPORT_MAX = 10;

   // Own copy of the table and the searched span
   logic signed [ITEM_BITS-1:0] table_copy [DEPTH];
   logic [COUNT_BITS-1:0]       span_count = '0;
   rsp_type                     expected_lookups [$];
   int                          fails = 0;
   int                          checked = 0;
   int                          hits = 0;

   // Iterative search over the first span_count entries, count saturated to the depth
   function automatic rsp_type lookup_key(logic signed [ITEM_BITS-1:0] key);
      int      lo_bound;
      int      hi_bound;
      int      mid;
      rsp_type answer;
      answer   = '0;
      lo_bound = 0;
      hi_bound = ((span_count > DEPTH) ? DEPTH : int'(span_count)) - 1;
      while (lo_bound <= hi_bound && !answer.found) begin
         mid = (lo_bound + hi_bound) / 2;
         if (key == table_copy[mid]) begin
            answer.found    = 1'b1;
            answer.position = mid[POS_BITS-1:0];
         end else if (key > table_copy[mid]) begin
            lo_bound = mid + 1;
         end else begin
            hi_bound = mid - 1;
         end
      end
      return answer;
   endfunction

   // Results are compared before the new beat is taken in: a search never answers at once
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         expected_lookups.delete();
         span_count = '0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_lookups.size() == 0) begin
               if (fails < REPORT_MAX)
                  $display("%0t: result beat found=%0d position=%0d with no search pending",
                           $time, rsp_data.found, rsp_data.position);
               fails++;
            end else begin
               want = expected_lookups.pop_front();
               checked++;
               if (want.found)
                  hits++;
               if (rsp_data.found !== want.found || rsp_data.position !== want.position) begin
                  if (fails < REPORT_MAX)
                     $display({"%0t: mismatch, expected found=%0d position=%0d, ",
                               "got found=%0d position=%0d"},
                              $time, want.found, want.position, rsp_data.found,
                              rsp_data.position);
                  fails++;
               end
            end
         end
         if (csr_wr_en)
            span_count = csr_wr_data;
         if (req_valid && !req_stall) begin
            if (req_data.kind == KIND_WRITE)
               table_copy[req_data.entry_index] = req_data.item_value;
            else
               expected_lookups.push_back(lookup_key(req_data.item_value));
         end
      end
      outstanding     <= expected_lookups.size();
      error_count     <= fails;
      results_checked <= checked;
      hits_seen       <= hits;
   end

endmodule

FILE: tb/sorted_table_binary_search_tb.sv
`timescale 1ns / 1ps
// Testbench top for the sorted table binary search: stimulus, idling and verdict.
module sorted_table_binary_search_tb;
   import stbs_pkg::*;

   localparam int DEPTH         = DEF_TABLE_DEPTH;
   localparam int ITEM_TARGET   = 1850;
   localparam int SETTLE_CYCLES = 30;
   localparam logic signed [ITEM_BITS-1:0] VAL_MIN = {1'b1, {(ITEM_BITS-1){1'b0}}};
   localparam logic signed [ITEM_BITS-1:0] VAL_MAX = {1'b0, {(ITEM_BITS-1){1'b1}}};
   localparam logic [COUNT_BITS-1:0] COUNT_TOP = '1;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   req_type               req_data    = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_wr_en   = 1'b0;
   logic [COUNT_BITS-1:0] csr_wr_data = '0;

   int send_gap_pct   = 33;
   int recv_stall_pct = 51;
   int beats_sent     = 0;
   int searches_sent  = 0;
   int sizes_used     = 0;
   int active_count   = 0;
   int fail_total;
   int waiting;
   int checked;
   int hits;

   // What the table holds, used only to pick keys
   logic signed [ITEM_BITS-1:0] shadow [DEPTH];

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   sorted_table_binary_search uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   stbs_result_check result_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data        (rsp_data),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .error_count     (fail_total),
      .outstanding     (waiting),
      .results_checked (checked),
      .hits_seen       (hits)
   );

   // Receiver back-pressure
   always @(posedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // One input beat, with random gaps ahead of it; valid stays up into the next beat
   task automatic send_beat(logic [KIND_BITS-1:0] kind, logic [INDEX_BITS-1:0] idx,
                            logic signed [ITEM_BITS-1:0] value);
      req_type beat;
      beat.kind        = kind;
      beat.entry_index = idx;
      beat.item_value  = value;
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      beats_sent++;
      if (kind == KIND_WRITE)
         shadow[idx] = value;
      else
         searches_sent++;
   endtask

   task automatic write_entry(logic [INDEX_BITS-1:0] idx, logic signed [ITEM_BITS-1:0] value);
      send_beat(KIND_WRITE, idx, value);
   endtask

   // Index field is don't-care on a search, so it carries noise
   task automatic search_key(logic signed [ITEM_BITS-1:0] key);
      send_beat(KIND_SEARCH, INDEX_BITS'($urandom), key);
   endtask

   // Drain, let any trailing write finish, then change the searched span
   task automatic set_entries_in_use(logic [COUNT_BITS-1:0] n);
      req_valid <= 1'b0;
      @(posedge clock);
      while (waiting != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= n;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      active_count = (n > DEPTH) ? DEPTH : int'(n);
      sizes_used++;
   endtask

   // Ascending run from a random start, steps from none (duplicates) to huge (top clamps)
   task automatic fill_sorted(int count);
      longint      level;
      int unsigned step_max;
      case ($urandom_range(3))
         0:       level = VAL_MIN;
         1:       level = $signed($urandom);
         default: level = longint'($urandom_range(2000)) - 1000;
      endcase
      case ($urandom_range(5))
         0:       step_max = 0;
         1:       step_max = 1;
         2:       step_max = 4;
         3:       step_max = 1000;
         4:       step_max = 32'h0100_0000;
         default: step_max = 32'h0400_0000;
      endcase
      for (int i = 0; i < count; i++) begin
         if (i > 0)
            level = level + $urandom_range(step_max);
         if (level > VAL_MAX)
            level = VAL_MAX;
         write_entry(i[INDEX_BITS-1:0], level[ITEM_BITS-1:0]);
      end
   endtask

   // Keys: mostly present, often just beside an entry, some wild, some at the extremes
   function automatic logic signed [ITEM_BITS-1:0] pick_key();
      int sel;
      int at;
      sel = $urandom_range(99);
      at  = (active_count > 0) ? int'($urandom_range(active_count - 1)) : 0;
      if (sel < 55)
         return shadow[at];
      else if (sel < 80)
         return shadow[at] + ($urandom_range(1) ? 1 : -1);
      else if (sel < 92)
         return $signed($urandom);
      else
         return $urandom_range(1) ? VAL_MIN : VAL_MAX;
   endfunction

   task automatic search_round(int count);
      for (int k = 0; k < count; k++) begin
         // occasional stray write: may break the ordering inside the span
         if ($urandom_range(99) < 6)
            write_entry(INDEX_BITS'($urandom), $signed($urandom));
         else
            search_key(pick_key());
      end
   endtask

   // Stimulus
   initial begin
      logic [COUNT_BITS-1:0] n;
      int                    sel;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty table
      set_entries_in_use('0);
      search_key(VAL_MIN);
      search_key('0);
      search_key(VAL_MAX);
      // small table with both extremes, and the last index
      write_entry(8'd0, VAL_MIN);
      write_entry(8'd1, -1);
      write_entry(8'd2, '0);
      write_entry(8'd3, VAL_MAX);
      write_entry(8'hFF, 32'sh5A5A_A5A5);
      set_entries_in_use(9'd1);
      search_key(VAL_MIN);
      search_key(5);
      set_entries_in_use(9'd4);
      search_key(VAL_MIN);
      search_key(-1);
      search_key('0);
      search_key(VAL_MAX);
      search_key(1);
      search_key(-2);
      search_key(VAL_MAX - 1);
      // unsorted table: same probes, whatever answer they give
      write_entry(8'd1, VAL_MAX);
      search_key('0);
      search_key(-1);
      search_key(VAL_MAX);

      // random rounds, starting on a full sorted table
      fill_sorted(DEPTH);
      set_entries_in_use(COUNT_BITS'(DEPTH));
      search_round($urandom_range(40, 70));
      while (beats_sent < ITEM_TARGET) begin
         if (beats_sent < ITEM_TARGET / 3) begin
            send_gap_pct   = 33;
            recv_stall_pct = 51;
         end else if (beats_sent < 2 * ITEM_TARGET / 3) begin
            send_gap_pct   = 51;
            recv_stall_pct = 33;
         end else begin
            send_gap_pct   = 0;
            recv_stall_pct = 0;
         end
         sel = $urandom_range(99);
         if (sel < 2)
            n = COUNT_BITS'(DEPTH);
         else if (sel < 4)
            n = COUNT_TOP;
         else if (sel < 5)
            n = COUNT_BITS'($urandom_range(DEPTH + 1, 510));
         else if (sel < 6)
            n = COUNT_BITS'(DEPTH - 1);
         else if (sel < 11)
            n = '0;
         else if (sel < 17)
            n = 9'd1;
         else if (sel < 21)
            n = 9'd2;
         else
            n = COUNT_BITS'($urandom_range(3, 40));
         set_entries_in_use(n);
         fill_sorted(active_count);
         search_round($urandom_range(25, 60));
      end

      // drain and verdict
      req_valid <= 1'b0;
      @(posedge clock);
      while (waiting != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Sent %0d beats: %0d searches and %0d table writes over %0d span settings.",
               beats_sent, searches_sent, beats_sent - searches_sent, sizes_used);
      $display("Checked %0d search results, %0d of them hits.", checked, hits);
      if (fail_total == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // Watchdog
   initial begin
      #4_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

FILE: filelist.f
sv/stbs_pkg.sv
sv/stbs_ram.sv
sv/stbs_dpath.sv
sv/stbs_ctrl.sv
sv/sorted_table_binary_search.sv
tb/stbs_result_check.sv
tb/sorted_table_binary_search_tb.sv
